### hdl/wsd_pkg.sv
// Shared types and codes for the work-stealing deque.
package wsd_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_PUSH_BOTTOM = 2'd0,
        KIND_POP_BOTTOM  = 2'd1,
        KIND_POP_TOP     = 2'd2,
        KIND_NONE        = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_RSVD  = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture request fields
        logic exec;   // evaluate indices, write or issue slot read
        logic emit;   // present slot read data as the result
    } ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic rd_pend; // current request needs a slot read
    } stat_t;

endpackage

### hdl/wsd_ctrl.sv
// Sequencing state machine for the work-stealing deque.
module wsd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  wsd_pkg::stat_t stat,
    output wsd_pkg::ctrl_t ctrl,
    output logic           busy
);

    wsd_pkg::state_t state_reg;
    wsd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        busy       = 1'b1;
        case (state_reg)
            wsd_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = wsd_pkg::ST_EXEC;
                end
            end
            wsd_pkg::ST_EXEC:
            begin
                ctrl.exec = 1'b1;
                // transfer with no slot read completes here
                state_next = stat.rd_pend ? wsd_pkg::ST_RESP : wsd_pkg::ST_IDLE;
            end
            wsd_pkg::ST_RESP:
            begin
                ctrl.emit  = 1'b1;
                state_next = wsd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wsd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/wsd_datapath.sv
// Slot store, index registers, generation tag and result registers.
module wsd_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  wsd_pkg::ctrl_t ctrl,
    output wsd_pkg::stat_t stat,
    input  logic [1:0]     kind,
    input  logic [31:0]    item,
    output logic           done,
    output logic [31:0]    result_item,
    output logic [1:0]     status,
    output logic [15:0]    generation
);

    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [31:0] slots [DEPTH];

    logic [1:0]        kind_reg;
    logic [31:0]       item_reg;
    logic [IDX_W-1:0]  bottom_reg, bottom_next;
    logic [IDX_W-1:0]  top_reg, top_next;
    logic [15:0]       tag_reg, tag_next;
    logic              done_reg;
    logic [31:0]       result_reg;
    logic [1:0]        status_reg;
    logic [31:0]       rd_data_reg;

    logic [IDX_W-1:0]  bot_dec;
    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  rd_idx;
    logic [1:0]        st_code;

    assign bot_dec = bottom_reg - IDX_W'(1);

    always_comb
    begin
        bottom_next = bottom_reg;
        top_next    = top_reg;
        tag_next    = tag_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        rd_idx      = top_reg;
        st_code     = wsd_pkg::STATUS_OK;
        case (kind_reg)
            wsd_pkg::KIND_PUSH_BOTTOM:
            begin
                if (bottom_reg == IDX_W'(DEPTH))
                begin
                    st_code = wsd_pkg::STATUS_FULL;
                end
                else
                begin
                    wr_en       = 1'b1;
                    bottom_next = bottom_reg + IDX_W'(1);
                end
            end
            wsd_pkg::KIND_POP_BOTTOM:
            begin
                if (bottom_reg == '0)
                begin
                    st_code = wsd_pkg::STATUS_EMPTY;
                end
                else
                begin
                    rd_idx = bot_dec;
                    if (bot_dec > top_reg)
                    begin
                        rd_en       = 1'b1;
                        bottom_next = bot_dec;
                    end
                    else
                    begin
                        // met the top: last item or lost to stealers, then rebase
                        bottom_next = '0;
                        top_next    = '0;
                        tag_next    = tag_reg + 16'd1;
                        if (bot_dec == top_reg)
                        begin
                            rd_en = 1'b1;
                        end
                        else
                        begin
                            st_code = wsd_pkg::STATUS_EMPTY;
                        end
                    end
                end
            end
            wsd_pkg::KIND_POP_TOP:
            begin
                if (bottom_reg <= top_reg)
                begin
                    st_code = wsd_pkg::STATUS_EMPTY;
                end
                else
                begin
                    rd_en    = 1'b1;
                    top_next = top_reg + IDX_W'(1);
                end
            end
            default:
            begin
                st_code = wsd_pkg::STATUS_EMPTY;
            end
        endcase
    end

    assign stat.rd_pend = rd_en;

    // slot store
    always_ff @(posedge clk)
    begin
        if (ctrl.exec && wr_en)
        begin
            slots[bottom_reg[ADDR_W-1:0]] <= item_reg;
        end
        if (ctrl.exec && rd_en)
        begin
            rd_data_reg <= slots[rd_idx[ADDR_W-1:0]];
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            kind_reg <= kind;
            item_reg <= item;
        end
        if (ctrl.exec)
        begin
            status_reg <= st_code;
            result_reg <= '0;
        end
        else if (ctrl.emit)
        begin
            result_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottom_reg <= '0;
            top_reg    <= '0;
            tag_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= (ctrl.exec && !rd_en) || ctrl.emit;
            if (ctrl.exec)
            begin
                bottom_reg <= bottom_next;
                top_reg    <= top_next;
                tag_reg    <= tag_next;
            end
        end
    end

    assign done        = done_reg;
    assign result_item = result_reg;
    assign status      = status_reg;
    assign generation  = tag_reg;

endmodule

### hdl/work_stealing_deque_top.sv
// Top level of the work-stealing deque: controller plus datapath.
//
// Work-stealing deque of DEPTH 32-bit task handles. A request (kind, item)
// transfers in at a rising edge with start high and busy low; exactly one
// result follows, shown on result_item, status and generation for a single
// cycle with done high. The receiver cannot hold results off, so it must
// take each result in the cycle done is high. A push, any request that
// answers empty or full, and an unknown kind finish in the evaluate state,
// with done registered from it; a pop that returns a handle goes on from
// evaluate to a response state and shows done registered from that state,
// which the registered read of the single-port slot memory calls for.
// busy is low again in the cycle done is shown, so the next request may
// transfer alongside the result. generation is the reset tag after the
// request; it advances whenever an owner pop meets the top, which also
// returns both indices to zero. The slot memory has no reset and needs
// no clearing pass.
module work_stealing_deque_top #(
    parameter int DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] item,
    output logic        done,
    output logic [31:0] result_item,
    output logic [1:0]  status,
    output logic [15:0] generation
);

    wsd_pkg::ctrl_t ctrl;
    wsd_pkg::stat_t stat;

    // sequencer: idle, evaluate, optional read response
    wsd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // slots, bottom and top indices, generation tag, result registers
    wsd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .kind        (kind),
        .item        (item),
        .done        (done),
        .result_item (result_item),
        .status      (status),
        .generation  (generation)
    );

endmodule
